FILE: rtl/lsb_audio_stego_embed_extract_assert.svh
// assertion macros shared by the lsb audio stego rtl
`ifndef LSB_AUDIO_STEGO_EMBED_EXTRACT_ASSERT_SVH
`define LSB_AUDIO_STEGO_EMBED_EXTRACT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define LASE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lase same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LASE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lase next-cycle check failed");

`endif

FILE: rtl/lase_pkg.sv
// shared types and constants of the lsb audio stego block
package lase_pkg;

  // zero bytes that form the end marker
  localparam int unsigned MARKER_LEN = 8;

  // command queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // result kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_BYTE      = 2'd1,
    KIND_FOUND     = 2'd2,
    KIND_NOT_FOUND = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_MSG_LEN = 1'b1
  } reg_idx_t;

  // mode register values
  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // one classified item: the results it expands to, in order
  typedef struct packed {
    logic        is_sample;
    logic [15:0] sample;
    logic [3:0]  zeros;
    logic        has_byte;
    logic [7:0]  data;
    logic        has_found;
    logic        has_nf;
  } cmd_t;

endpackage

FILE: rtl/lase_front.sv
// front end: config registers, stream state, item classification
`include "lsb_audio_stego_embed_extract_assert.svh"

module lase_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  lase_pkg::reg_idx_t cfg_index,
  input  logic [19:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_sample,
  input  logic [7:0]        in_message_byte,
  input  logic              in_last_sample,
  input  logic              q_full,
  output logic              push,
  output lase_pkg::cmd_t    cmd
);
  import lase_pkg::*;

  logic        mode_r;
  logic [19:0] msg_len_r;
  logic [2:0]  bit_pos_r, bit_pos_nxt;
  logic [7:0]  byte_shift_r, byte_shift_nxt;
  logic [7:0]  cpb_r, cpb_nxt;
  logic [20:0] bytes_done_r, bytes_done_nxt;
  logic [3:0]  zero_run_r, zero_run_nxt;
  logic        finished_r, finished_nxt;

  logic        accept;
  logic [2:0]  bp_inc;
  logic        wrap;
  logic [7:0]  cpb_cur;
  logic [20:0] bd_inc;
  logic [20:0] end_cnt;
  logic [7:0]  shift;
  logic [3:0]  zr_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // shared arithmetic
  assign bp_inc  = bit_pos_r + 3'd1;
  assign wrap    = (bp_inc == 3'd0);
  assign cpb_cur = (bit_pos_r != 3'd0) ? cpb_r :
                   ((bytes_done_r < {1'b0, msg_len_r}) ? in_message_byte : 8'd0);
  assign bd_inc  = bytes_done_r + 21'd1;
  assign end_cnt = {1'b0, msg_len_r} + 21'(MARKER_LEN);
  assign shift   = {byte_shift_r[6:0], in_sample[0]};
  assign zr_inc  = zero_run_r + 4'd1;

  // next stream state and command
  always_comb begin
    bit_pos_nxt    = bit_pos_r;
    byte_shift_nxt = byte_shift_r;
    cpb_nxt        = cpb_r;
    bytes_done_nxt = bytes_done_r;
    zero_run_nxt   = zero_run_r;
    finished_nxt   = finished_r;
    cmd            = '0;
    push           = 1'b0;
    if (accept) begin
      if (mode_r == MODE_EMBED) begin
        cmd.is_sample = 1'b1;
        cmd.sample    = in_sample;
        if (!finished_r) begin
          cpb_nxt       = cpb_cur;
          cmd.sample    = {in_sample[15:1], cpb_cur[3'd7 - bit_pos_r]};
          bit_pos_nxt   = bp_inc;
          if (wrap) begin
            bytes_done_nxt = bd_inc;
            if (bd_inc >= end_cnt) begin
              finished_nxt = 1'b1;
            end
          end
        end
      end else begin
        if (!finished_r) begin
          byte_shift_nxt = shift;
          bit_pos_nxt    = bp_inc;
          if (wrap) begin
            byte_shift_nxt = 8'd0;
            if (shift == 8'd0) begin
              zero_run_nxt = zr_inc;
              if (zr_inc >= 4'(MARKER_LEN)) begin
                zero_run_nxt  = 4'd0;
                finished_nxt  = 1'b1;
                cmd.has_found = 1'b1;
              end
            end else begin
              cmd.zeros    = zero_run_r;
              cmd.has_byte = 1'b1;
              cmd.data     = shift;
              zero_run_nxt = 4'd0;
            end
          end
        end
        cmd.has_nf = in_last_sample && !finished_nxt;
      end
      push = cmd.is_sample || cmd.has_byte || cmd.has_found || cmd.has_nf;
      // end of stream returns the stream state to reset
      if (in_last_sample) begin
        bit_pos_nxt    = 3'd0;
        byte_shift_nxt = 8'd0;
        cpb_nxt        = 8'd0;
        bytes_done_nxt = 21'd0;
        zero_run_nxt   = 4'd0;
        finished_nxt   = 1'b0;
      end
    end
  end

  // config and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_EMBED;
      msg_len_r    <= 20'd0;
      bit_pos_r    <= 3'd0;
      byte_shift_r <= 8'd0;
      cpb_r        <= 8'd0;
      bytes_done_r <= 21'd0;
      zero_run_r   <= 4'd0;
      finished_r   <= 1'b0;
    end else begin
      bit_pos_r    <= bit_pos_nxt;
      byte_shift_r <= byte_shift_nxt;
      cpb_r        <= cpb_nxt;
      bytes_done_r <= bytes_done_nxt;
      zero_run_r   <= zero_run_nxt;
      finished_r   <= finished_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:    mode_r    <= cfg_data[0];
          REG_MSG_LEN: msg_len_r <= cfg_data;
          default:     mode_r    <= mode_r;
        endcase
      end
    end
  end

  `LASE_ASSERT_SAME(a_zero_run_bound, clk, rst_n, 1'b1, zero_run_r < 4'(MARKER_LEN))

endmodule

FILE: rtl/lase_cmd_queue.sv
// small command queue between front and back
`include "lsb_audio_stego_embed_extract_assert.svh"

module lase_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lase_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output lase_pkg::cmd_t cmd_out,
  output logic           empty
);
  import lase_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;

  assign full    = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign cmd_out = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `LASE_ASSERT_SAME(a_q_bound, clk, rst_n, 1'b1, cnt_r <= (Q_PTR_W+1)'(Q_DEPTH))
  `LASE_ASSERT_SAME(a_q_ptr_full, clk, rst_n, full, wr_ptr_r == rd_ptr_r)

endmodule

FILE: rtl/lase_back.sv
// back end: expands commands into result transfers, one per cycle unless stalled
`include "lsb_audio_stego_embed_extract_assert.svh"

module lase_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  lase_pkg::cmd_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output lase_pkg::kind_t out_kind,
  output logic [15:0]     out_sample_out,
  output logic [7:0]      out_data_byte,
  output logic            out_last
);
  import lase_pkg::*;

  logic        cur_valid_r, cur_valid_nxt;
  cmd_t        cur_r, cur_nxt;
  logic        out_valid_r;
  kind_t       kind_r;
  logic [15:0] sample_r;
  logic [7:0]  data_r;
  logic        last_r;

  logic        slot_free;
  logic        issue;
  cmd_t        after;
  kind_t       res_kind;
  logic [15:0] res_sample;
  logic [7:0]  res_data;
  logic        remaining;
  logic        cur_done;

  assign slot_free = !out_valid_r || out_ready;
  assign issue     = slot_free && cur_valid_r;

  // pick the next result of the current command
  always_comb begin
    after      = cur_r;
    res_kind   = KIND_NOT_FOUND;
    res_sample = 16'd0;
    res_data   = 8'd0;
    if (cur_r.is_sample) begin
      res_kind        = KIND_SAMPLE;
      res_sample      = cur_r.sample;
      after.is_sample = 1'b0;
    end else if (cur_r.zeros != 4'd0) begin
      res_kind    = KIND_BYTE;
      after.zeros = cur_r.zeros - 4'd1;
    end else if (cur_r.has_byte) begin
      res_kind       = KIND_BYTE;
      res_data       = cur_r.data;
      after.has_byte = 1'b0;
    end else if (cur_r.has_found) begin
      res_kind        = KIND_FOUND;
      after.has_found = 1'b0;
    end else begin
      after.has_nf = 1'b0;
    end
    remaining = after.is_sample || (after.zeros != 4'd0) || after.has_byte ||
                after.has_found || after.has_nf;
  end

  // load the next command once the current one is used up
  assign cur_done = !cur_valid_r || (issue && !remaining);
  assign q_pop    = cur_done && !q_empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_nxt       = cur_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_nxt       = q_head;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (issue) begin
      cur_nxt = after;
    end
  end

  // current command and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    cur_r <= cur_nxt;
    if (issue) begin
      kind_r   <= res_kind;
      sample_r <= res_sample;
      data_r   <= res_data;
      last_r   <= !remaining;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_sample_out = sample_r;
  assign out_data_byte  = data_r;
  assign out_last       = last_r;

  `LASE_ASSERT_SAME(a_cur_nonempty, clk, rst_n, cur_valid_r,
    cur_r.is_sample || cur_r.zeros != 4'd0 || cur_r.has_byte || cur_r.has_found || cur_r.has_nf)
  `LASE_ASSERT_NEXT(a_cur_held, clk, rst_n, issue && remaining, cur_valid_r)

endmodule

FILE: rtl/lsb_audio_stego_embed_extract.sv
// top level of the lsb audio stego embed and extract block
// Hides a byte payload in bit 0 of 16-bit audio samples (mode 0) or recovers it
// (mode 1). The input side takes one sample per cycle and stalls only once the
// queue is full; the front end updates the bit and byte counters in that same
// cycle and, for items with results, queues a command into a four-entry queue.
// The back end turns each command into result transfers at one per cycle unless
// stalled, through a registered output stage. Embed mode gives one result per
// sample, so it keeps that rate end to end. In extract mode a nonzero byte
// after held zero bytes, and a missing end marker at stream end, give up to
// nine results for one sample; these drain at one per cycle unless stalled.
// Results carry last on the final transfer caused by one sample. Configuration
// writes are taken every cycle and must only be made while the block is idle.
module lsb_audio_stego_embed_extract (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  lase_pkg::reg_idx_t cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_sample,
  input  logic [7:0]         in_message_byte,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output lase_pkg::kind_t    out_kind,
  output logic [15:0]        out_sample_out,
  output logic [7:0]         out_data_byte,
  output logic               out_last
);
  import lase_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic q_pop;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // classification and stream state
  lase_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_message_byte (in_message_byte),
    .in_last_sample  (in_last_sample),
    .q_full          (q_full),
    .push            (push),
    .cmd             (cmd_in)
  );

  // decoupling queue
  lase_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (cmd_head),
    .empty   (q_empty)
  );

  // result expansion and output stage
  lase_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (cmd_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_sample_out (out_sample_out),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last)
  );

endmodule
